// ===== hw/rtl/sss_pkg.sv =====
package sss_pkg;

    // Fixed field widths of the channels and registers
    localparam int WORD_W     = 31;
    localparam int RKIND_W    = 2;
    localparam int ENTRY_W    = 24;
    localparam int ROW_IDX_W  = 20;
    localparam int NROWS_W    = 21;
    localparam int NCOLS_W    = 21;
    localparam int PERCOL_W   = 5;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_COLS   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PER_COLUMN = 2'd2;

    localparam logic [NCOLS_W-1:0] COL_LIMIT = 21'h100000;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_WORD  = 1'b1;

    typedef enum logic [RKIND_W-1:0] {
        RK_SIGN   = 2'd0,
        RK_ROW    = 2'd1,
        RK_REJECT = 2'd2
    } t_rkind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SIGNS = 2'd1,
        PH_ROWS  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LIMIT,
        ST_SIGN,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_PUT
    } t_state;

    typedef struct packed {
        t_rkind               result_kind;
        logic [ENTRY_W-1:0]   entry_index;
        logic                 sign_bit;
        logic [ROW_IDX_W-1:0] row_index;
        logic                 last;
        logic                 done_res;
    } t_res;

endpackage

// ===== hw/rtl/sss_intf.sv =====
interface sss_req_if;
    import sss_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output kind, output random_word, input ready);
    modport sink   (input valid, input kind, input random_word, output ready);
endinterface

interface sss_res_if;
    import sss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RKIND_W-1:0]   result_kind;
    logic [ENTRY_W-1:0]   entry_index;
    logic                 sign_bit;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 last;
    logic                 done_res;

    modport source (output valid, output result_kind, output entry_index, output sign_bit,
                    output row_index, output last, output done_res, input ready);
    modport sink   (input valid, input result_kind, input entry_index, input sign_bit,
                    input row_index, input last, input done_res, output ready);
endinterface

// ===== hw/rtl/sss_ram.sv =====
module sss_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/sparse_sign_sketch_generator.sv =====
// Channel  | Dir | Payload                                               | Handshake
// i_req    | in  | kind, random_word                                     | valid/ready
// o_res    | out | result_kind, entry_index, sign_bit, row_index,        | valid/ready
//          |     | last, done_res                                        |
// APB      | in  | num_rows, num_cols, per_column at 0x0, 0x4, 0x8       | psel/penable
//
// Start request: clamps the registers, then the bit-serial remainder unit sets the limit.
// Sign word: one sign emitted per cycle while the output slot is free, up to RANDOM_BITS.
// Row word: divided by the remainder unit, then each stored row is compared in the
//   duplicate scan over the row store's read port; a word over the limit skips both.
// Reset clears all control state; the row store needs no clearing.
// A stalled output holds the sequencer at the next result; one result is buffered.
module sparse_sign_sketch_generator #(
    parameter int RANDOM_BITS    = 31,
    parameter int MAX_PER_COLUMN = 16,
    parameter int ROW_BITS       = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sss_req_if.sink                           i_req,
    sss_res_if.source                         o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sss_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sss_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sss_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import sss_pkg::*;

    localparam int ER_W   = ROW_BITS + 1;
    localparam int SU_W   = ROW_BITS + 2;
    localparam int CW     = (ROW_BITS + 2 > NROWS_W + 1) ? ROW_BITS + 2 : NROWS_W + 1;
    localparam int ACC_W  = $clog2(MAX_PER_COLUMN + 1);
    localparam int IDX_W  = (MAX_PER_COLUMN > 1) ? $clog2(MAX_PER_COLUMN) : 1;
    localparam int TOT_W  = NCOLS_W + ACC_W;
    localparam int BIT_W  = $clog2(RANDOM_BITS);
    localparam logic [RANDOM_BITS-1:0] RMAX = {RANDOM_BITS{1'b1}};
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(RANDOM_BITS - 1);

    // configuration registers
    logic [NROWS_W-1:0]  r_num_rows;
    logic [NCOLS_W-1:0]  r_num_cols;
    logic [PERCOL_W-1:0] r_per_column;

    // control state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [ER_W-1:0]     r_eff_rows, n_eff_rows;
    logic [NCOLS_W-1:0]  r_eff_cols, n_eff_cols;
    logic [ACC_W-1:0]    r_eff_zeta, n_eff_zeta;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [TOT_W-1:0]    r_entry, n_entry;
    logic [NCOLS_W-1:0]  r_col, n_col;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [RANDOM_BITS-1:0] r_limit, n_limit;
    logic                r_start, n_start;
    logic                r_ovalid, n_ovalid;

    // datapath
    logic [RANDOM_BITS-1:0] r_div, n_div;
    logic [ROW_BITS-1:0]    r_rem, n_rem;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic [ACC_W-1:0]       r_scan, n_scan;
    t_rkind                 r_pend, n_pend;
    t_res                   r_res, n_res;
    logic                   load_out;

    // shared subtract / compare unit
    logic [ER_W-1:0]  trial;
    logic [SU_W-1:0]  su_a, su_b, su_diff;
    logic             su_neg, su_zero;

    logic [ROW_BITS-1:0] ram_rdata;
    logic                ram_we;

    logic                   in_fire, slot_free;
    logic [RANDOM_BITS-1:0] word;
    logic [CW-1:0]          c_rows, c_zeta;
    logic [TOT_W-1:0]       entry_inc;
    logic                   entries_end, sign_last;
    logic [ACC_W-1:0]       acc_inc;
    logic [NCOLS_W-1:0]     col_inc;
    logic                   cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb begin
        case (paddr[REG_IDX_W+1:2])
            REG_NUM_ROWS:   prdata = APB_DATA_W'(r_num_rows);
            REG_NUM_COLS:   prdata = APB_DATA_W'(r_num_cols);
            REG_PER_COLUMN: prdata = APB_DATA_W'(r_per_column);
            default:        prdata = '0;
        endcase
    end

    assign in_fire   = i_req.valid & i_req.ready;
    assign slot_free = ~r_ovalid | o_res.ready;
    assign word      = i_req.random_word[RANDOM_BITS-1:0];

    assign i_req.ready = (r_state == ST_IDLE);

    assign o_res.valid       = r_ovalid;
    assign o_res.result_kind = r_res.result_kind;
    assign o_res.entry_index = r_res.entry_index;
    assign o_res.sign_bit    = r_res.sign_bit;
    assign o_res.row_index   = r_res.row_index;
    assign o_res.last        = r_res.last;
    assign o_res.done_res    = r_res.done_res;

    assign trial = {r_rem, r_div[RANDOM_BITS-1]};

    always_comb begin
        if (r_state == ST_SCAN_CMP) begin
            su_a = SU_W'(r_rem);
            su_b = SU_W'(ram_rdata);
        end else begin
            su_a = SU_W'(trial);
            su_b = SU_W'(r_eff_rows);
        end
        su_diff = su_a - su_b;
        su_neg  = su_diff[SU_W-1];
        su_zero = (su_diff == '0);
    end

    assign entry_inc   = r_entry + TOT_W'(1);
    assign entries_end = (entry_inc >= r_total);
    assign sign_last   = entries_end | (r_bit == LAST_BIT);
    assign acc_inc     = r_acc + ACC_W'(1);
    assign col_inc     = r_col + NCOLS_W'(1);

    sss_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(MAX_PER_COLUMN)
    ) u_rows (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_acc[IDX_W-1:0]),
        .i_wdata(r_rem),
        .i_raddr(r_scan[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_eff_rows = r_eff_rows;
        n_eff_cols = r_eff_cols;
        n_eff_zeta = r_eff_zeta;
        n_total    = r_total;
        n_entry    = r_entry;
        n_col      = r_col;
        n_acc      = r_acc;
        n_limit    = r_limit;
        n_start    = r_start;
        n_div      = r_div;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_scan     = r_scan;
        n_pend     = r_pend;
        n_res      = r_res;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        c_rows     = '0;
        c_zeta     = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_req.kind == KIND_START) begin
                        // saturate the registers into their legal ranges
                        c_rows = CW'(r_num_rows);
                        if (c_rows == '0) begin
                            c_rows = CW'(1);
                        end else if (c_rows > (CW'(1) << ROW_BITS)) begin
                            c_rows = CW'(1) << ROW_BITS;
                        end
                        c_zeta = CW'(r_per_column);
                        if (c_zeta == '0) begin
                            c_zeta = CW'(1);
                        end else if (c_zeta > CW'(MAX_PER_COLUMN)) begin
                            c_zeta = CW'(MAX_PER_COLUMN);
                        end
                        if (c_zeta > c_rows) begin
                            c_zeta = c_rows;
                        end
                        n_eff_rows = ER_W'(c_rows);
                        n_eff_zeta = ACC_W'(c_zeta);
                        if (r_num_cols == '0) begin
                            n_eff_cols = NCOLS_W'(1);
                        end else if (r_num_cols > COL_LIMIT) begin
                            n_eff_cols = COL_LIMIT;
                        end else begin
                            n_eff_cols = r_num_cols;
                        end
                        n_entry = '0;
                        n_col   = '0;
                        n_acc   = '0;
                        n_div   = RMAX;
                        n_rem   = '0;
                        n_bit   = '0;
                        n_start = 1'b1;
                        n_state = ST_DIV;
                    end else if (r_phase == PH_SIGNS) begin
                        n_div   = word;
                        n_bit   = '0;
                        n_state = ST_SIGN;
                    end else if (r_phase == PH_ROWS) begin
                        if (word > r_limit) begin
                            n_pend  = RK_REJECT;
                            n_state = ST_PUT;
                        end else begin
                            n_div   = word;
                            n_rem   = '0;
                            n_bit   = '0;
                            n_start = 1'b0;
                            n_state = ST_DIV;
                        end
                    end
                end
            end

            ST_DIV: begin
                // one restoring remainder step per cycle, MSB first
                n_rem = su_neg ? trial[ROW_BITS-1:0] : su_diff[ROW_BITS-1:0];
                n_div = r_div << 1;
                n_bit = r_bit + BIT_W'(1);
                if (r_bit == LAST_BIT) begin
                    n_scan  = '0;
                    n_state = r_start ? ST_LIMIT : ST_SCAN_RD;
                end
            end

            ST_LIMIT: begin
                n_limit = RMAX - RANDOM_BITS'(r_rem);
                n_total = TOT_W'(r_eff_cols) * TOT_W'(r_eff_zeta);
                n_phase = PH_SIGNS;
                n_state = ST_IDLE;
            end

            ST_SIGN: begin
                if (slot_free) begin
                    load_out              = 1'b1;
                    n_res.result_kind     = RK_SIGN;
                    n_res.entry_index     = ENTRY_W'(r_entry);
                    n_res.sign_bit        = r_div[0];
                    n_res.row_index       = '0;
                    n_res.last            = sign_last;
                    n_res.done_res        = 1'b0;
                    n_div                 = r_div >> 1;
                    n_bit                 = r_bit + BIT_W'(1);
                    n_entry               = entry_inc;
                    if (sign_last) begin
                        n_state = ST_IDLE;
                        if (entries_end) begin
                            n_phase = PH_ROWS;
                            n_entry = '0;
                        end
                    end
                end
            end

            ST_SCAN_RD: begin
                if (r_scan >= r_acc) begin
                    n_pend  = RK_ROW;
                    n_state = ST_PUT;
                end else begin
                    n_state = ST_SCAN_CMP;
                end
            end

            ST_SCAN_CMP: begin
                if (su_zero) begin
                    n_pend  = RK_REJECT;
                    n_state = ST_PUT;
                end else begin
                    n_scan  = r_scan + ACC_W'(1);
                    n_state = ST_SCAN_RD;
                end
            end

            ST_PUT: begin
                if (slot_free) begin
                    load_out          = 1'b1;
                    n_res.entry_index = ENTRY_W'(r_entry);
                    n_res.sign_bit    = 1'b0;
                    n_res.last        = 1'b1;
                    n_res.done_res    = 1'b0;
                    n_state           = ST_IDLE;
                    if (r_pend == RK_ROW) begin
                        n_res.result_kind = RK_ROW;
                        n_res.row_index   = ROW_IDX_W'(r_rem);
                        ram_we            = 1'b1;
                        n_entry           = entry_inc;
                        n_acc             = acc_inc;
                        if (acc_inc >= r_eff_zeta) begin
                            n_acc = '0;
                            n_col = col_inc;
                            if (col_inc >= r_eff_cols) begin
                                n_phase        = PH_DONE;
                                n_res.done_res = 1'b1;
                            end
                        end
                    end else begin
                        n_res.result_kind = RK_REJECT;
                        n_res.row_index   = '0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hold the buffered result until the sink takes it
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (o_res.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows   <= NROWS_W'(1);
            r_num_cols   <= NCOLS_W'(1);
            r_per_column <= PERCOL_W'(1);
        end else if (cfg_we) begin
            case (paddr[REG_IDX_W+1:2])
                REG_NUM_ROWS:   r_num_rows   <= pwdata[NROWS_W-1:0];
                REG_NUM_COLS:   r_num_cols   <= pwdata[NCOLS_W-1:0];
                REG_PER_COLUMN: r_per_column <= pwdata[PERCOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_IDLE;
            r_eff_rows <= ER_W'(1);
            r_eff_cols <= NCOLS_W'(1);
            r_eff_zeta <= ACC_W'(1);
            r_total    <= TOT_W'(1);
            r_entry    <= '0;
            r_col      <= '0;
            r_acc      <= '0;
            r_limit    <= '0;
            r_start    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_eff_rows <= n_eff_rows;
            r_eff_cols <= n_eff_cols;
            r_eff_zeta <= n_eff_zeta;
            r_total    <= n_total;
            r_entry    <= n_entry;
            r_col      <= n_col;
            r_acc      <= n_acc;
            r_limit    <= n_limit;
            r_start    <= n_start;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_scan <= n_scan;
        r_pend <= n_pend;
        r_res  <= n_res;
    end

endmodule
